### hdl/circle_square_overlap_culler_macros.svh
// Assertion macros used by the checker of the overlap culler.
`ifndef CIRCLE_SQUARE_OVERLAP_CULLER_MACROS_SVH
`define CIRCLE_SQUARE_OVERLAP_CULLER_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define CHS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is low.
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/chs_pkg.sv
// Types, widths and codes shared by the circle/square overlap culler.
package chs_pkg;

    // Table depth default
    localparam int MAX_ENTRIES_DEF = 32;

    // Field widths
    localparam int COORD_W     = 24;
    localparam int RAD_W       = 23;
    localparam int SIZE_W      = 16;
    localparam int GRID_W      = 8;
    localparam int LVL_W       = 4;
    localparam int MASK_W      = 32;
    localparam int COUNT_OUT_W = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Internal widths: square bounds, axis gaps, squares, mask index
    localparam int BOX_W  = 35;
    localparam int GAP_W  = BOX_W - 1;
    localparam int SQ_W   = 2 * RAD_W;
    localparam int MIDX_W = $clog2(MASK_W);

    // Register stages in the evaluation unit
    localparam int EVAL_LAT = 2;
    localparam int DRAIN_W  = (EVAL_LAT > 1) ? $clog2(EVAL_LAT) : 1;

    // Request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TEST  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 2'd2;

    localparam logic [SIZE_W-1:0] SQUARE_SIZE_RST = 16'd2048;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] circle_x;
        logic signed [COORD_W-1:0] circle_y;
        logic [RAD_W-1:0]          circle_radius;
        logic                      on_terrain;
        logic [GRID_W-1:0]         square_x;
        logic [GRID_W-1:0]         square_y;
        logic [LVL_W-1:0]          square_level;
        logic [MASK_W-1:0]         candidate_mask;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0]      surviving_mask;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   load_taken;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [RAD_W-1:0]          r;
    } t_circle;

    typedef struct packed {
        logic signed [BOX_W-1:0] lo_x;
        logic signed [BOX_W-1:0] hi_x;
        logic signed [BOX_W-1:0] lo_y;
        logic signed [BOX_W-1:0] hi_y;
    } t_box;

    // Circle handed to the evaluation unit this cycle
    typedef struct packed {
        logic              valid;
        logic [MIDX_W-1:0] idx;
    } t_probe;

    // Evaluation result: clear mask bit idx
    typedef struct packed {
        logic              clear;
        logic [MIDX_W-1:0] idx;
    } t_verdict;

endpackage

### hdl/chs_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
interface chs_req_if;
    logic          valid;
    logic          ready;
    chs_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/chs_res_if.sv
// Result channel: valid/ready handshake carrying one result item.
interface chs_res_if;
    logic             valid;
    logic             ready;
    chs_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/chs_cell.sv
// One table cell: holds a circle, loads it or takes its neighbour's.
module chs_cell (
    input  logic             i_clk,
    input  logic             i_load,
    input  chs_pkg::t_circle i_load_data,
    input  logic             i_shift,
    input  chs_pkg::t_circle i_next,
    output chs_pkg::t_circle o_data
);

    chs_pkg::t_circle r_circle;
    chs_pkg::t_circle n_circle;

    // Load has priority; loads and shifts never meet in practice
    always_comb begin
        n_circle = r_circle;
        if (i_load) begin
            n_circle = i_load_data;
        end else if (i_shift) begin
            n_circle = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_circle <= n_circle;
    end

    assign o_data = r_circle;

endmodule

### hdl/chs_eval.sv
// Shared distance test: axis gaps, squares, then sum against radius squared.
module chs_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chs_pkg::t_probe   i_probe,
    input  chs_pkg::t_circle  i_circle,
    input  chs_pkg::t_box     i_box,
    output chs_pkg::t_verdict o_verdict
);

    localparam int BOX_W  = chs_pkg::BOX_W;
    localparam int GAP_W  = chs_pkg::GAP_W;
    localparam int RAD_W  = chs_pkg::RAD_W;
    localparam int SQ_W   = chs_pkg::SQ_W;
    localparam int MIDX_W = chs_pkg::MIDX_W;

    // Distance from p to [lo, hi], zero inside
    function automatic logic [GAP_W-1:0] axis_gap(
        input logic signed [BOX_W-1:0] p,
        input logic signed [BOX_W-1:0] lo,
        input logic signed [BOX_W-1:0] hi
    );
        logic signed [BOX_W-1:0] d;
        d = '0;
        if (p < lo) begin
            d = lo - p;
        end else if (p > hi) begin
            d = p - hi;
        end
        return d[GAP_W-1:0];
    endfunction

    // Stage 1: gaps
    logic              r_s1_valid;
    logic [MIDX_W-1:0] r_s1_idx;
    logic [GAP_W-1:0]  r_s1_gx;
    logic [GAP_W-1:0]  r_s1_gy;
    logic [RAD_W-1:0]  r_s1_r;

    // Stage 2: squares and the early far flag
    logic              r_s2_valid;
    logic [MIDX_W-1:0] r_s2_idx;
    logic              r_s2_far;
    logic [SQ_W-1:0]   r_s2_sx;
    logic [SQ_W-1:0]   r_s2_sy;
    logic [SQ_W-1:0]   r_s2_sr;

    logic [GAP_W-1:0]  n_s1_gx;
    logic [GAP_W-1:0]  n_s1_gy;
    logic              n_s2_far;
    logic [SQ_W-1:0]   n_s2_sx;
    logic [SQ_W-1:0]   n_s2_sy;
    logic [SQ_W-1:0]   n_s2_sr;
    logic [SQ_W:0]     w_sum;

    always_comb begin
        n_s1_gx = axis_gap(BOX_W'(i_circle.x), i_box.lo_x, i_box.hi_x);
        n_s1_gy = axis_gap(BOX_W'(i_circle.y), i_box.lo_y, i_box.hi_y);
    end

    // A gap beyond the radius decides at once; otherwise it fits RAD_W bits
    always_comb begin
        n_s2_far = (r_s1_gx > GAP_W'(r_s1_r)) || (r_s1_gy > GAP_W'(r_s1_r));
        n_s2_sx  = SQ_W'(r_s1_gx[RAD_W-1:0]) * SQ_W'(r_s1_gx[RAD_W-1:0]);
        n_s2_sy  = SQ_W'(r_s1_gy[RAD_W-1:0]) * SQ_W'(r_s1_gy[RAD_W-1:0]);
        n_s2_sr  = SQ_W'(r_s1_r) * SQ_W'(r_s1_r);
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_probe.valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_probe.idx;
        r_s1_gx  <= n_s1_gx;
        r_s1_gy  <= n_s1_gy;
        r_s1_r   <= i_circle.r;
        r_s2_idx <= r_s1_idx;
        r_s2_far <= n_s2_far;
        r_s2_sx  <= n_s2_sx;
        r_s2_sy  <= n_s2_sy;
        r_s2_sr  <= n_s2_sr;
    end

    // Stage 3: final compare
    assign w_sum = (SQ_W+1)'(r_s2_sx) + (SQ_W+1)'(r_s2_sy);
    assign o_verdict.clear = r_s2_valid && (r_s2_far || (w_sum > (SQ_W+1)'(r_s2_sr)));
    assign o_verdict.idx   = r_s2_idx;

endmodule

### hdl/circle_square_overlap_culler.sv
// Top level of the circle/square overlap culler: cell ring, controller, result register.
//
//   channel   dir  handshake        payload
//   i_req     in   valid / ready    chs_pkg::t_req
//   o_res     out  valid / ready    chs_pkg::t_result
//   i_cfg_*   in   i_cfg_we only    index i_cfg_idx, data i_cfg_data
//
// Load, clear and unused requests are answered straight from the idle state. A test forms
// the square bounds in the setup and bound states, rotates the ring of cells past the shared
// evaluation unit, drains that unit, then posts the result once the output is free.
// Reset is synchronous and active low; it empties the table and restores the registers.
// A stalled result holds the block in place; no new item is taken until it can leave.
module circle_square_overlap_culler #(
    parameter int MAX_ENTRIES = chs_pkg::MAX_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [chs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [chs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    chs_req_if.sink                          i_req,
    chs_res_if.source                        o_res
);

    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int EXT_W   = (CNT_W > chs_pkg::COUNT_OUT_W) ? CNT_W : chs_pkg::COUNT_OUT_W;
    localparam int BOX_W   = chs_pkg::BOX_W;
    localparam int MIDX_W  = chs_pkg::MIDX_W;
    localparam int DRAIN_W = chs_pkg::DRAIN_W;
    localparam int COORD_W = chs_pkg::COORD_W;
    localparam int PROD_W  = chs_pkg::GRID_W + chs_pkg::SIZE_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_BOUND = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    function automatic logic [chs_pkg::COUNT_OUT_W-1:0] count_field(
        input logic [CNT_W-1:0] c
    );
        logic [EXT_W-1:0] e;
        e = EXT_W'(c);
        return e[chs_pkg::COUNT_OUT_W-1:0];
    endfunction

    // Control and configuration registers
    logic [2:0]                         r_state,  n_state;
    logic [CNT_W-1:0]                   r_count,  n_count;
    logic                               r_out_valid, n_out_valid;
    logic [chs_pkg::SIZE_W-1:0]         r_size,   n_size;
    logic signed [COORD_W-1:0]          r_org_x,  n_org_x;
    logic signed [COORD_W-1:0]          r_org_y,  n_org_y;

    // Test working registers
    logic [CNT_W-1:0]                   r_step,   n_step;
    logic [DRAIN_W-1:0]                 r_drain,  n_drain;
    logic [chs_pkg::GRID_W-1:0]         r_sq_x,   n_sq_x;
    logic [chs_pkg::GRID_W-1:0]         r_sq_y,   n_sq_y;
    logic [chs_pkg::LVL_W-1:0]          r_level,  n_level;
    logic [chs_pkg::MASK_W-1:0]         r_mask,   n_mask;
    logic [BOX_W-1:0]                   r_sz,     n_sz;
    chs_pkg::t_box                      r_box,    n_box;
    chs_pkg::t_result                   r_res,    n_res;

    logic                               w_fire;
    logic                               w_out_free;
    logic                               w_load_ok;
    logic                               w_load_we;
    logic                               w_shift;
    logic [PROD_W-1:0]                  w_prod_x;
    logic [PROD_W-1:0]                  w_prod_y;
    logic [EXT_W-1:0]                   w_step_ext;
    chs_pkg::t_probe                    w_probe;
    chs_pkg::t_verdict                  w_verdict;
    chs_pkg::t_circle                   w_load_data;
    chs_pkg::t_circle                   w_cell [MAX_ENTRIES];

    // Handshakes
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_fire      = i_req.valid && i_req.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    // Load path into the cell at the fill position
    assign w_load_ok = i_req.data.on_terrain && (r_count < CNT_W'(MAX_ENTRIES));
    assign w_load_we = w_fire && (i_req.data.req_type == chs_pkg::REQ_LOAD) && w_load_ok;
    assign w_shift   = (r_state == ST_RUN);

    assign w_load_data.x = i_req.data.circle_x;
    assign w_load_data.y = i_req.data.circle_y;
    assign w_load_data.r = i_req.data.circle_radius;

    // Ring of cells; cell 0 faces the evaluation unit
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        chs_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_load_we && (r_count == CNT_W'(g))),
            .i_load_data (w_load_data),
            .i_shift     (w_shift),
            .i_next      (w_cell[(g + 1) % MAX_ENTRIES]),
            .o_data      (w_cell[g])
        );
    end

    // Probe for the circle now at the head of the ring
    assign w_step_ext    = EXT_W'(r_step);
    assign w_probe.idx   = w_step_ext[MIDX_W-1:0];
    assign w_probe.valid = (r_state == ST_RUN) && (r_step < r_count)
                           && (w_step_ext < EXT_W'(chs_pkg::MASK_W))
                           && r_mask[w_probe.idx];

    chs_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_probe   (w_probe),
        .i_circle  (w_cell[0]),
        .i_box     (r_box),
        .o_verdict (w_verdict)
    );

    // Grid offsets of the square's low corner
    assign w_prod_x = PROD_W'(r_sq_x) * PROD_W'(r_size);
    assign w_prod_y = PROD_W'(r_sq_y) * PROD_W'(r_size);

    // Controller
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_res.ready;
        n_size      = r_size;
        n_org_x     = r_org_x;
        n_org_y     = r_org_y;
        n_step      = r_step;
        n_drain     = r_drain;
        n_sq_x      = r_sq_x;
        n_sq_y      = r_sq_y;
        n_level     = r_level;
        n_mask      = r_mask;
        n_sz        = r_sz;
        n_box       = r_box;
        n_res       = r_res;

        case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    if (i_req.data.req_type == chs_pkg::REQ_TEST) begin
                        n_sq_x  = i_req.data.square_x;
                        n_sq_y  = i_req.data.square_y;
                        n_level = i_req.data.square_level;
                        n_mask  = i_req.data.candidate_mask;
                        n_state = ST_SETUP;
                    end else begin
                        if (i_req.data.req_type == chs_pkg::REQ_CLEAR) begin
                            n_count = '0;
                        end else if (w_load_we) begin
                            n_count = r_count + CNT_W'(1);
                        end
                        n_out_valid          = 1'b1;
                        n_res.surviving_mask = '0;
                        n_res.entry_count    = count_field(n_count);
                        n_res.load_taken     = w_load_we;
                    end
                end
            end
            ST_SETUP: begin
                n_box.lo_x = BOX_W'(signed'({1'b0, w_prod_x})) + BOX_W'(r_org_x);
                n_box.lo_y = BOX_W'(signed'({1'b0, w_prod_y})) + BOX_W'(r_org_y);
                n_sz       = BOX_W'(r_size) << r_level;
                n_state    = ST_BOUND;
            end
            ST_BOUND: begin
                n_box.hi_x = r_box.lo_x + signed'(r_sz);
                n_box.hi_y = r_box.lo_y + signed'(r_sz);
                n_step     = '0;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                n_step = r_step + CNT_W'(1);
                if (r_step == CNT_W'(MAX_ENTRIES - 1)) begin
                    n_drain = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + DRAIN_W'(1);
                if (r_drain == DRAIN_W'(chs_pkg::EVAL_LAT - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid          = 1'b1;
                    n_res.surviving_mask = r_mask;
                    n_res.entry_count    = count_field(r_count);
                    n_res.load_taken     = 1'b0;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Drop candidates the evaluation unit found out of reach
        if (w_verdict.clear) begin
            n_mask[w_verdict.idx] = 1'b0;
        end

        // Configuration writes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                chs_pkg::CFG_SQUARE_SIZE: n_size  = i_cfg_data[chs_pkg::SIZE_W-1:0];
                chs_pkg::CFG_ORIGIN_X:    n_org_x = signed'(i_cfg_data[COORD_W-1:0]);
                chs_pkg::CFG_ORIGIN_Y:    n_org_y = signed'(i_cfg_data[COORD_W-1:0]);
                default: ;
            endcase
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_size      <= chs_pkg::SQUARE_SIZE_RST;
            r_org_x     <= '0;
            r_org_y     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_size      <= n_size;
            r_org_x     <= n_org_x;
            r_org_y     <= n_org_y;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_drain <= n_drain;
        r_sq_x  <= n_sq_x;
        r_sq_y  <= n_sq_y;
        r_level <= n_level;
        r_mask  <= n_mask;
        r_sz    <= n_sz;
        r_box   <= n_box;
        r_res   <= n_res;
    end

endmodule

### hdl/chs_checker.sv
// Port-level checks for the overlap culler, bound to the top level.
`include "circle_square_overlap_culler_macros.svh"

module chs_checker #(
    parameter int MAX_ENTRIES = chs_pkg::MAX_ENTRIES_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input chs_pkg::t_req    i_req_data,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input chs_pkg::t_result i_res_data
);

    localparam int CW = chs_pkg::COUNT_OUT_W + 1;

    logic                       r_last_clear;
    logic                       r_last_load;
    logic [chs_pkg::MASK_W-1:0] r_last_mask;
    logic                       w_req_fire;

    assign w_req_fire = i_req_valid && i_req_ready;

    // Remember what the latest accepted item asked for
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_clear <= 1'b0;
            r_last_load  <= 1'b0;
            r_last_mask  <= '0;
        end else if (w_req_fire) begin
            r_last_clear <= (i_req_data.req_type == chs_pkg::REQ_CLEAR);
            r_last_load  <= (i_req_data.req_type == chs_pkg::REQ_LOAD);
            r_last_mask  <= (i_req_data.req_type == chs_pkg::REQ_TEST)
                            ? i_req_data.candidate_mask : '0;
        end
    end

    `CHS_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_data), "result item changed while stalled")
    `CHS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, i_res_valid, CW'(i_res_data.entry_count) <= CW'(MAX_ENTRIES), "entry count beyond table depth")
    `CHS_ASSERT_IMPL(a_mask_subset, i_clk, i_rst_n, i_res_valid, (i_res_data.surviving_mask & ~r_last_mask) == '0, "surviving mask sets a bit not asked for")
    `CHS_ASSERT_IMPL(a_clear_empty, i_clk, i_rst_n, i_res_valid && r_last_clear, i_res_data.entry_count == '0, "table not empty after clear")
    `CHS_ASSERT_IMPL(a_taken_on_load, i_clk, i_rst_n, i_res_valid && i_res_data.load_taken, r_last_load, "load taken flagged for a non-load item")

endmodule

bind circle_square_overlap_culler chs_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_chs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_data  (i_req.data),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
